[design/wat_pkg.sv]
package wat_pkg;

    // table geometry
    localparam int MAX_ALARMS   = 16;
    localparam int RESULT_LIMIT = 16;
    localparam int IDX_W  = (MAX_ALARMS > 1) ? $clog2(MAX_ALARMS) : 1;
    localparam int CNT_W  = $clog2(MAX_ALARMS + 1);
    localparam int FIRE_W = $clog2(RESULT_LIMIT + 1);

    // field widths
    localparam int CMD_W    = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int REPEAT_W = 7;
    localparam int ID_W     = 16;
    localparam int DAY_W    = 3;
    localparam int STATUS_W = 3;
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 56;

    // time limits for an add and id counter range
    localparam logic [HOUR_W-1:0]   HOUR_MAX   = 5'd23;
    localparam logic [MINUTE_W-1:0] MINUTE_MAX = 6'd59;
    localparam logic [ID_W-1:0]     ID_FIRST   = 16'd1;
    localparam logic [ID_W-1:0]     ID_LAST    = 16'hFFFF;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_ENABLE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_QUERY  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd4;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_TIME  = 3'd1;
    localparam logic [STATUS_W-1:0] ST_FULL      = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
    localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;
    localparam logic [STATUS_W-1:0] ST_NONE      = 3'd5;

    // one stored alarm
    typedef struct packed {
        logic [ID_W-1:0]     id;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
        logic                en;
        logic [REPEAT_W-1:0] rep;
    } t_entry;

    // one result beat
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        t_entry              entry;
        logic [ID_W-1:0]     next_id;
        logic                last;
    } t_result;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic add_do;
        logic walk_init;
        logic rd;
        logic ev_step;
        logic fin_push;
    } t_dp_cmd;

    // datapath to controller
    typedef struct packed {
        logic is_add;
        logic is_walk;
        logic walk_empty;
        logic ev_last;
        logic ev_stall;
        logic out_free;
    } t_dp_stat;

endpackage

[design/weekday_alarm_table_core.sv]
// Alarm table of up to 16 entries kept in insertion order in a small RAM.
// Commands come in as one beat each (command code in tuser); add, remove,
// set enable and query give one result beat, a minute tick gives one beat
// per fired alarm (up to 16) or a single "nothing fired" beat, with tlast on
// the final beat. Remove, set enable, query and tick walk every stored entry
// through the RAM read port, reading each entry in S_RD and evaluating it in
// S_EV; the walk holds while a fired result waits on a stalled result side.
// Removal of an entry, including a one-time alarm that fires, closes the gap
// during that same walk. A new command beat is accepted once the previous one
// has finished, even while its last result still waits on the output
// register. The table RAM needs no clearing after reset.
module weekday_alarm_table_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    // hour[4:0], minute[10:5], repeat[17:11], target_id[33:18], enable[34],
    // weekday[37:35], zero pad[39:38]
    input  logic [wat_pkg::S_DATA_W-1:0] i_s_tdata,
    // cmd[2:0]
    input  logic [wat_pkg::CMD_W-1:0]    i_s_tuser,
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    // status[2:0], alarm_id[18:3], hour[23:19], minute[29:24], enabled[30],
    // repeat[37:31], next_id[53:38], zero pad[55:54]
    output logic [wat_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                         o_m_tlast
);

    wat_pkg::t_dp_cmd  dp_cmd;
    wat_pkg::t_dp_stat dp_stat;

    wat_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd)
    );

    wat_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tready (i_m_tready),
        .o_m_tvalid (o_m_tvalid),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cmd      (dp_cmd),
        .o_stat     (dp_stat)
    );

endmodule

[design/wat_ram.sv]
module wat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                     i_clk,
    input  logic                                     i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                         i_wdata,
    input  logic                                     i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/wat_dp.sv]
module wat_dp (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [wat_pkg::S_DATA_W-1:0] i_s_tdata,
    input  logic [wat_pkg::CMD_W-1:0]    i_s_tuser,
    input  logic                         i_m_tready,
    output logic                         o_m_tvalid,
    output logic [wat_pkg::M_DATA_W-1:0] o_m_tdata,
    output logic                         o_m_tlast,
    input  wat_pkg::t_dp_cmd             i_cmd,
    output wat_pkg::t_dp_stat            o_stat
);

    localparam int IDX_W  = wat_pkg::IDX_W;
    localparam int CNT_W  = wat_pkg::CNT_W;
    localparam int FIRE_W = wat_pkg::FIRE_W;

    // captured item
    logic [wat_pkg::CMD_W-1:0]    r_cmd;
    logic [wat_pkg::HOUR_W-1:0]   r_hour;
    logic [wat_pkg::MINUTE_W-1:0] r_minute;
    logic [wat_pkg::REPEAT_W-1:0] r_rep;
    logic [wat_pkg::ID_W-1:0]     r_tid;
    logic                         r_en;
    logic [wat_pkg::DAY_W-1:0]    r_day;

    // table control
    logic [CNT_W-1:0]         r_count, n_count;
    logic [wat_pkg::ID_W-1:0] r_id_ctr, n_id_ctr;
    logic [IDX_W-1:0]         r_rd, n_rd;
    logic [CNT_W-1:0]         r_wr, n_wr;
    logic [FIRE_W-1:0]        r_fires, n_fires;

    // pending and output results
    logic                r_pend_v, n_pend_v;
    wat_pkg::t_result    r_pend, n_pend;
    logic                r_out_v, n_out_v;
    wat_pkg::t_result    r_out, n_out;

    // ram port
    logic                ram_we;
    logic [IDX_W-1:0]    ram_waddr;
    wat_pkg::t_entry     ram_wdata;
    wat_pkg::t_entry     ram_q;

    // entry evaluation
    logic                is_tick;
    logic                out_free;
    logic                match;
    logic                drop;
    logic                need_push;
    logic [wat_pkg::REPEAT_W:0] rep_ext;
    logic                day_hit;
    wat_pkg::t_entry     wr_entry;
    wat_pkg::t_entry     new_entry;
    logic                bad_time;
    logic                full;
    logic [CNT_W-1:0]    wr_next;

    wat_ram #(
        .WIDTH ($bits(wat_pkg::t_entry)),
        .DEPTH (wat_pkg::MAX_ALARMS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (i_cmd.rd),
        .i_raddr (r_rd),
        .o_rdata (ram_q)
    );

    // match logic for the entry on the ram output
    always_comb begin
        is_tick  = (r_cmd == wat_pkg::CMD_TICK);
        out_free = !r_out_v || i_m_tready;
        rep_ext  = {1'b0, ram_q.rep};
        day_hit  = (ram_q.rep == '0) || rep_ext[r_day];
        if (is_tick) begin
            match = ram_q.en && (ram_q.hour == r_hour) && (ram_q.minute == r_minute)
                    && day_hit && (r_fires != FIRE_W'(wat_pkg::RESULT_LIMIT));
        end else begin
            match = !r_pend_v && (ram_q.id == r_tid);
        end
        drop = match && ((r_cmd == wat_pkg::CMD_REMOVE) || (is_tick && ram_q.rep == '0));
        wr_entry = ram_q;
        if (match && r_cmd == wat_pkg::CMD_ENABLE) begin
            wr_entry.en = r_en;
        end
        need_push = is_tick && match && r_pend_v;
        wr_next   = r_wr + CNT_W'(!drop);
    end

    // add checks
    always_comb begin
        bad_time         = (r_hour > wat_pkg::HOUR_MAX) || (r_minute > wat_pkg::MINUTE_MAX);
        full             = (r_count == CNT_W'(wat_pkg::MAX_ALARMS));
        new_entry.id     = r_id_ctr;
        new_entry.hour   = r_hour;
        new_entry.minute = r_minute;
        new_entry.en     = 1'b1;
        new_entry.rep    = r_rep;
    end

    // next-state of the datapath
    always_comb begin
        n_count   = r_count;
        n_id_ctr  = r_id_ctr;
        n_rd      = r_rd;
        n_wr      = r_wr;
        n_fires   = r_fires;
        n_pend_v  = r_pend_v;
        n_pend    = r_pend;
        n_out     = r_out;
        n_out_v   = i_m_tready ? 1'b0 : r_out_v;
        ram_we    = 1'b0;
        ram_waddr = r_wr[IDX_W-1:0];
        ram_wdata = wr_entry;

        if (i_cmd.add_do) begin
            n_out        = '0;
            n_out.last   = 1'b1;
            n_out_v      = 1'b1;
            if (bad_time) begin
                n_out.status = wat_pkg::ST_BAD_TIME;
            end else if (full) begin
                n_out.status = wat_pkg::ST_FULL;
            end else begin
                ram_we       = 1'b1;
                ram_waddr    = r_count[IDX_W-1:0];
                ram_wdata    = new_entry;
                n_count      = r_count + CNT_W'(1);
                n_id_ctr     = (r_id_ctr == wat_pkg::ID_LAST) ? wat_pkg::ID_FIRST
                                                              : r_id_ctr + 16'd1;
                n_out.status = wat_pkg::ST_OK;
                n_out.entry  = new_entry;
            end
            n_out.next_id = n_id_ctr;
        end

        if (i_cmd.walk_init) begin
            n_rd     = '0;
            n_wr     = '0;
            n_fires  = '0;
            n_pend_v = 1'b0;
        end

        // one entry of a walk: keep or drop, maybe report
        if (i_cmd.ev_step) begin
            ram_we = !drop;
            n_rd   = r_rd + IDX_W'(1);
            n_wr   = wr_next;
            if (need_push) begin
                n_out      = r_pend;
                n_out.last = 1'b0;
                n_out_v    = 1'b1;
            end
            if (match) begin
                n_pend_v       = 1'b1;
                n_pend.status  = is_tick ? wat_pkg::ST_FIRED : wat_pkg::ST_OK;
                n_pend.entry   = wr_entry;
                n_pend.next_id = r_id_ctr;
                n_pend.last    = 1'b0;
                if (is_tick) begin
                    n_fires = r_fires + FIRE_W'(1);
                end
            end
            if (o_stat.ev_last) begin
                n_count = wr_next;
            end
        end

        if (i_cmd.fin_push) begin
            n_out_v = 1'b1;
            if (r_pend_v) begin
                n_out = r_pend;
            end else begin
                n_out        = '0;
                n_out.status = is_tick ? wat_pkg::ST_NONE : wat_pkg::ST_NOT_FOUND;
            end
            n_out.next_id = r_id_ctr;
            n_out.last    = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_id_ctr <= wat_pkg::ID_FIRST;
            r_rd     <= '0;
            r_wr     <= '0;
            r_fires  <= '0;
            r_pend_v <= 1'b0;
            r_out_v  <= 1'b0;
        end else begin
            r_count  <= n_count;
            r_id_ctr <= n_id_ctr;
            r_rd     <= n_rd;
            r_wr     <= n_wr;
            r_fires  <= n_fires;
            r_pend_v <= n_pend_v;
            r_out_v  <= n_out_v;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pend <= n_pend;
        r_out  <= n_out;
        if (i_cmd.load) begin
            r_cmd    <= i_s_tuser;
            r_hour   <= i_s_tdata[4:0];
            r_minute <= i_s_tdata[10:5];
            r_rep    <= i_s_tdata[17:11];
            r_tid    <= i_s_tdata[33:18];
            r_en     <= i_s_tdata[34];
            r_day    <= i_s_tdata[37:35];
        end
    end

    // status to the controller
    always_comb begin
        o_stat.is_add     = (r_cmd == wat_pkg::CMD_ADD);
        o_stat.is_walk    = (r_cmd == wat_pkg::CMD_REMOVE) || (r_cmd == wat_pkg::CMD_ENABLE)
                            || (r_cmd == wat_pkg::CMD_QUERY) || (r_cmd == wat_pkg::CMD_TICK);
        o_stat.walk_empty = (r_count == '0);
        o_stat.ev_last    = ((CNT_W'(r_rd) + CNT_W'(1)) == r_count);
        o_stat.ev_stall   = need_push && !out_free;
        o_stat.out_free   = out_free;
    end

    // result port
    assign o_m_tvalid = r_out_v;
    assign o_m_tlast  = r_out.last;
    assign o_m_tdata  = {2'b00, r_out.next_id, r_out.entry.rep, r_out.entry.en,
                         r_out.entry.minute, r_out.entry.hour, r_out.entry.id,
                         r_out.status};

    // table never holds more than its depth
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(wat_pkg::MAX_ALARMS))
        else $error("alarm count above table depth");

    // id counter skips zero
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_id_ctr != '0)
        else $error("id counter reached zero");

    // a walk only removes entries
    a_walk_shrinks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.ev_step && o_stat.ev_last) |=> (r_count <= $past(r_count)))
        else $error("walk grew the table");

    // fire count stays within the per-tick limit
    a_fire_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fires <= FIRE_W'(wat_pkg::RESULT_LIMIT))
        else $error("too many fires in one tick");

endmodule

[design/wat_ctrl.sv]
module wat_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  wat_pkg::t_dp_stat i_stat,
    output wat_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEC,
        S_ADD,
        S_RD,
        S_EV,
        S_FIN
    } t_state;

    t_state r_state, n_state;

    // sequencing of one item
    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DEC;
                end
            end
            S_DEC: begin
                if (i_stat.is_add) begin
                    n_state = S_ADD;
                end else if (i_stat.is_walk) begin
                    o_cmd.walk_init = 1'b1;
                    n_state = i_stat.walk_empty ? S_FIN : S_RD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_ADD: begin
                if (i_stat.out_free) begin
                    o_cmd.add_do = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EV;
            end
            S_EV: begin
                if (!i_stat.ev_stall) begin
                    o_cmd.ev_step = 1'b1;
                    n_state = i_stat.ev_last ? S_FIN : S_RD;
                end
            end
            S_FIN: begin
                if (i_stat.out_free) begin
                    o_cmd.fin_push = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);

endmodule
